[rtl/gops_pkg.sv]
`default_nettype none
package gops_pkg;

  localparam int unsigned DivNumW = 24;
  localparam int unsigned DivDenW = 16;

  localparam logic [17:0] SynthMax    = 18'd262080;
  localparam logic [15:0] PeriodReset = 16'd12800;
  localparam logic [17:0] PeriodMin   = 18'd1280;
  localparam logic [17:0] PeriodMax   = 18'd51200;
  localparam logic [10:0] RatioOne    = 11'd256;
  localparam logic [10:0] RatioMax    = 11'd1024;
  localparam logic [19:0] AccMax      = 20'sd524287;
  localparam logic [19:0] AccMin      = 20'h80000;
  // ceil(2^18 / 5), exact quotient for numerators below 2^18
  localparam logic [15:0] RecipFive   = 16'd52429;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
    logic [DivDenW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/grain_overlap_add_pitch_shifter.sv]
`default_nettype none
// channel | direction | handshake             | fields
// in      | input     | in_valid_i/in_ready_o | sample_in_i, block_start_i, pitch_ratio_i,
//         |           |                       | detected_period_i
// out     | output    | out_valid_o/out_ready_i | sample_out_o
// one word at a time; an accepted word is written to the input ring, the phase is
// advanced, and one output word is read from the accumulation ring and emitted;
// a block start first adds the smoothing multiply and the serial divider, and a
// grain that fires adds the divider, len read-modify-writes and a drain (len at
// most 1600); after reset the two rings are cleared, one entry a cycle,
// with in_ready_o low
// the next word is taken while the previous result waits in the output register
module grain_overlap_add_pitch_shifter #(
  parameter int unsigned RING_DEPTH        = 4096,
  parameter int unsigned WINDOW_TABLE_SIZE = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_in_i,
  input  wire logic        block_start_i,
  input  wire logic [10:0] pitch_ratio_i,
  input  wire logic [15:0] detected_period_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      sample_out_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned TW = $clog2(WINDOW_TABLE_SIZE);
  localparam int unsigned NW = gops_pkg::DivNumW;
  localparam int unsigned DW = gops_pkg::DivDenW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV1, ST_DIV2, ST_WRITE, ST_PHASE, ST_DIVW,
    ST_GRAIN, ST_DRAIN, ST_ORD, ST_OWR
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic          issued_q;
  logic [15:0]   samp_q;
  logic [10:0]   ratio_q;
  logic [15:0]   det_q;
  logic [31:0]   count_q;
  logic [AW-1:0] rdp_q, gp_q;
  logic [17:0]   phase_q;
  logic [15:0]   smooth_q;
  logic [17:0]   synth_q;
  logic [10:0]   len_q, g_q;
  logic [39:0]   idx_q;
  logic [AW-1:0] dst_q;
  logic [TW-1:0] wi_q;
  logic [TW:0]   q0_q;
  logic [10:0]   r0_q, wrem_q;
  logic          s1_q, s2_q;
  logic [AW-1:0] dst1_q, dst2_q;
  logic signed [32:0] prod_q;
  logic [19:0]   acc2_q;
  logic          out_valid_q;
  logic [15:0]   out_q;

  logic [15:0] in_ring [RING_DEPTH];
  logic [19:0] acc_ring [RING_DEPTH];
  logic [15:0] in_rd_q;
  logic [19:0] acc_rd_q;
  logic [15:0] win_w;

  gops_pkg::div_req_t div_req;
  gops_pkg::div_rsp_t div_rsp;

  logic [10:0] rfix;
  logic [17:0] pclamp, p4;
  logic [17:0] snum;
  logic [33:0] smul;
  logic [17:0] ph;
  logic signed [39:0] cval, cneg, centre, gstart;
  logic [10:0] len_w;
  logic [11:0] rsum;
  logic        carry;
  logic [TW+1:0] wnext;
  logic        issue;
  logic [AW-1:0] src_addr;
  logic signed [33:0] contrib_w;
  logic signed [20:0] sum_w;
  logic [19:0] sat_w;
  logic        oslot;

  assign rfix = (ratio_q == 11'd0 || ratio_q > gops_pkg::RatioMax) ?
                gops_pkg::RatioOne : ratio_q;
  assign p4 = {det_q, 2'b00};
  assign pclamp = (p4 < gops_pkg::PeriodMin) ? gops_pkg::PeriodMin :
                  (p4 > gops_pkg::PeriodMax) ? gops_pkg::PeriodMax : p4;
  // smoothing divide by five as a reciprocal multiply
  assign snum = {smooth_q, 2'b00} + pclamp + 18'd2;
  assign smul = {16'd0, snum} * {18'd0, gops_pkg::RecipFive};
  assign ph = phase_q + 18'd64;
  assign len_w = smooth_q[15:5];
  assign cval = $signed({2'b00, count_q, 6'b000000}) - $signed({24'd0, smooth_q});
  assign cneg = -cval;
  assign centre = cval[39] ? -$signed({6'd0, cneg[39:6]}) : $signed({6'd0, cval[39:6]});
  assign gstart = centre - $signed({30'd0, len_w[10:1]});
  assign rsum = {1'b0, wrem_q} + {1'b0, r0_q};
  assign carry = rsum >= {1'b0, len_q};
  assign wnext = {2'b00, wi_q} + {1'b0, q0_q} + {{(TW+1){1'b0}}, carry};
  assign issue = (state_q == ST_GRAIN);
  assign src_addr = idx_q[39] ? '0 : idx_q[AW-1:0];
  assign contrib_w = ($signed({prod_q[32], prod_q}) + 34'sd16384) >>> 15;
  assign sum_w = $signed({acc2_q[19], acc2_q}) + $signed(contrib_w[20:0]);
  assign sat_w = (sum_w > $signed({1'b0, gops_pkg::AccMax})) ? gops_pkg::AccMax :
                 (sum_w < $signed({1'b1, gops_pkg::AccMin})) ? gops_pkg::AccMin :
                 sum_w[19:0];
  assign oslot = !out_valid_q || out_ready_i;

  always_comb begin
    div_req = '0;
    case (state_q)
      ST_DIV2: begin
        div_req.start = !issued_q;
        div_req.num   = NW'({smooth_q, 8'd0}) + NW'(rfix[10:1]);
        div_req.den   = DW'(rfix);
      end
      ST_DIVW: begin
        div_req.start = !issued_q;
        div_req.num   = NW'(WINDOW_TABLE_SIZE);
        div_req.den   = DW'(len_q);
      end
      default: div_req = '0;
    endcase
  end

  gops_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gops_win #(
    .WINDOW_TABLE_SIZE (WINDOW_TABLE_SIZE)
  ) u_win (
    .clk_i  (clk_i),
    .en_i   (issue),
    .addr_i (wi_q),
    .data_o (win_w)
  );

  // input ring
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      in_ring[clr_q] <= '0;
    end else if (state_q == ST_WRITE) begin
      in_ring[count_q[AW-1:0]] <= samp_q;
    end
    if (issue) begin
      in_rd_q <= in_ring[src_addr];
    end
  end

  // accumulation ring
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      acc_ring[clr_q] <= '0;
    end else if (s2_q) begin
      acc_ring[dst2_q] <= sat_w;
    end else if (state_q == ST_OWR && oslot) begin
      acc_ring[rdp_q] <= '0;
    end
    if (issue) begin
      acc_rd_q <= acc_ring[dst_q];
    end else if (state_q == ST_ORD) begin
      acc_rd_q <= acc_ring[rdp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(in_rd_q) * $signed({1'b0, win_w});
    acc2_q <= acc_rd_q;
    dst1_q <= dst_q;
    dst2_q <= dst1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      issued_q    <= 1'b0;
      count_q     <= '0;
      rdp_q       <= '0;
      gp_q        <= '0;
      phase_q     <= '0;
      smooth_q    <= gops_pkg::PeriodReset;
      synth_q     <= {2'b00, gops_pkg::PeriodReset};
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      g_q         <= '0;
    end else begin
      s1_q <= issue;
      s2_q <= s1_q;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == {AW{1'b1}}) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            samp_q  <= sample_in_i;
            ratio_q <= pitch_ratio_i;
            det_q   <= detected_period_i;
            state_q <= block_start_i ? ST_DIV1 : ST_WRITE;
          end
        end
        ST_DIV1: begin
          smooth_q <= smul[33:18];
          state_q  <= ST_DIV2;
        end
        ST_DIV2: begin
          issued_q <= 1'b1;
          if (issued_q && div_rsp.done) begin
            issued_q <= 1'b0;
            synth_q  <= (div_rsp.quot > NW'(gops_pkg::SynthMax)) ? gops_pkg::SynthMax :
                        div_rsp.quot[17:0];
            state_q  <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          count_q <= count_q + 32'd1;
          state_q <= ST_PHASE;
        end
        ST_PHASE: begin
          if (ph >= synth_q) begin
            phase_q <= ph - synth_q;
            len_q   <= len_w;
            idx_q   <= gstart;
            dst_q   <= gp_q;
            gp_q    <= gp_q + AW'(synth_q[17:6]);
            g_q     <= '0;
            wi_q    <= '0;
            wrem_q  <= '0;
            state_q <= ST_DIVW;
          end else begin
            phase_q <= ph;
            state_q <= ST_ORD;
          end
        end
        ST_DIVW: begin
          issued_q <= 1'b1;
          if (issued_q && div_rsp.done) begin
            issued_q <= 1'b0;
            q0_q     <= div_rsp.quot[TW:0];
            r0_q     <= div_rsp.rem[10:0];
            state_q  <= ST_GRAIN;
          end
        end
        ST_GRAIN: begin
          g_q    <= g_q + 11'd1;
          idx_q  <= idx_q + 40'sd1;
          dst_q  <= dst_q + AW'(1);
          wi_q   <= wnext[TW-1:0];
          wrem_q <= carry ? 11'(rsum - {1'b0, len_q}) : rsum[10:0];
          if (g_q == len_q - 11'd1) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_q && !s2_q) begin
            state_q <= ST_ORD;
          end
        end
        ST_ORD: begin
          state_q <= ST_OWR;
        end
        ST_OWR: begin
          if (oslot) begin
            out_valid_q <= 1'b1;
            out_q <= ($signed(acc_rd_q) > 20'sd32767) ? 16'h7fff :
                     ($signed(acc_rd_q) < -20'sd32768) ? 16'h8000 : acc_rd_q[15:0];
            rdp_q   <= rdp_q + AW'(1);
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_q && !s2_q)) else $error("grain pipe busy in idle");
  a_wb_in_grain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q |-> (state_q == ST_GRAIN || state_q == ST_DRAIN)) else $error("stray write-back");
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV2 || state_q == ST_DIVW))
    else $error("divider result unclaimed");
  a_accept_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE)) else $error("word dropped");

endmodule
`default_nettype wire

[rtl/gops_div.sv]
`default_nettype none
module gops_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gops_pkg::div_req_t req_i,
  output gops_pkg::div_rsp_t     rsp_o
);

  localparam int unsigned NW = gops_pkg::DivNumW;
  localparam int unsigned DW = gops_pkg::DivDenW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[NW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DW'(trial - {1'b0, den_q});
        num_d = {num_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        num_d = {num_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without run");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider not running after start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while running");

endmodule
`default_nettype wire

[rtl/gops_win.sv]
`default_nettype none
module gops_win #(
  parameter int unsigned WINDOW_TABLE_SIZE = 1024
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic [$clog2(WINDOW_TABLE_SIZE)-1:0] addr_i,
  output logic [15:0]                               data_o
);

  localparam logic [63:0] OneQ30 = 64'd1073741824;
  localparam logic [63:0] PiQ30  = 64'd3373259426;

  typedef logic [15:0] tab_t [WINDOW_TABLE_SIZE];

  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] tt;
    logic [63:0] s;
    logic [63:0] w;
    for (int i = 0; i < WINDOW_TABLE_SIZE; i++) begin
      r  = (i <= WINDOW_TABLE_SIZE / 2) ? 64'(i) : 64'(WINDOW_TABLE_SIZE - i);
      x  = (PiQ30 * r) / WINDOW_TABLE_SIZE;
      x2 = (x * x) >> 30;
      tt = OneQ30 - x2 / 72;
      tt = OneQ30 - ((x2 * tt) >> 30) / 42;
      tt = OneQ30 - ((x2 * tt) >> 30) / 20;
      tt = OneQ30 - ((x2 * tt) >> 30) / 6;
      s  = (x * tt) >> 30;
      w  = (s * s + (64'd1 << 44)) >> 45;
      if (w > 64'd32768) w = 64'd32768;
      t[i] = w[15:0];
    end
    return t;
  endfunction

  localparam tab_t WinTab = build_tab();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= WinTab[addr_i];
    end
  end

endmodule
`default_nettype wire
